// File: design/rgbhsv_pkg.sv
package rgbhsv_pkg;

  // Hue scale: 1/64 degree per unit.
  localparam int HUE_W = 15;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE_BASE = 15'd15360;

  // Divider chain geometry. The hue quotient is at most 3840, so twelve
  // quotient bits cover it; the saturation quotient needs eight of them.
  localparam int NUM_CELLS = 12;
  localparam int QH_W = 12;
  localparam int QS_W = 8;
  localparam int REMH_W = 20;
  localparam int REMS_W = 16;
  localparam int DSH_W = 19;

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic [REMH_W-1:0] rem_h;
    logic [DSH_W-1:0] dsh_h;
    logic [QH_W-1:0] q_h;
    logic [REMS_W-1:0] rem_s;
    logic [DSH_W-1:0] dsh_s;
    logic [QS_W-1:0] q_s;
    logic [HUE_W-1:0] off;
    logic neg;
    logic zero;
    logic [7:0] bright;
  } cell_data_t;

endpackage

// File: design/rgbhsv_if.sv
// Pixel channel: one RGB pixel per request.
interface rgbhsv_pix_if;
  logic valid;
  logic ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// Result channel: one HSV triple per request.
interface rgbhsv_hsv_if;
  logic valid;
  logic ready;
  logic [14:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

// File: design/rgbhsv_front.sv
module rgbhsv_front (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic in_valid,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic out_valid,
  output rgbhsv_pkg::cell_data_t out_data
);

  logic [7:0] mx;
  logic [7:0] mn;
  logic [7:0] d;
  logic [7:0] p;
  logic [7:0] n;
  logic [7:0] mag;
  logic neg;
  logic [rgbhsv_pkg::HUE_W-1:0] off;
  rgbhsv_pkg::cell_data_t data_next;

  // Largest and smallest channel.
  always_comb begin
    mx = (red > green) ? red : green;
    if (blue > mx) mx = blue;
    mn = (red < green) ? red : green;
    if (blue < mn) mn = blue;
    d = mx - mn;
  end

  // Sector select, red first, then green, then blue.
  always_comb begin
    if (mx == red) begin
      p = green;
      n = blue;
      off = (green >= blue) ? '0 : rgbhsv_pkg::HUE_FULL;
    end else if (mx == green) begin
      p = blue;
      n = red;
      off = rgbhsv_pkg::HUE_GREEN_BASE;
    end else begin
      p = red;
      n = green;
      off = rgbhsv_pkg::HUE_BLUE_BASE;
    end
    neg = (p < n);
    mag = neg ? (n - p) : (p - n);
  end

  // Dividends, and divisors aligned to the top quotient bit.
  always_comb begin
    data_next.rem_h = rgbhsv_pkg::REMH_W'(mag) * rgbhsv_pkg::REMH_W'(rgbhsv_pkg::HUE_SECTOR);
    data_next.dsh_h = {d, 11'b0};
    data_next.q_h = '0;
    data_next.rem_s = rgbhsv_pkg::REMS_W'({8'b0, d} * 16'd255);
    data_next.dsh_s = {mx, 11'b0};
    data_next.q_s = '0;
    data_next.off = off;
    data_next.neg = neg;
    data_next.zero = (d == 8'd0);
    data_next.bright = mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= data_next;
    end
  end

endmodule

// File: design/rgbhsv_cell.sv
module rgbhsv_cell (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  logic in_valid,
  input  rgbhsv_pkg::cell_data_t in_data,
  output logic out_valid,
  output rgbhsv_pkg::cell_data_t out_data
);

  logic [rgbhsv_pkg::REMH_W-1:0] dh;
  logic [rgbhsv_pkg::REMH_W-1:0] ds;
  logic [rgbhsv_pkg::REMH_W-1:0] rs_wide;
  logic take_h;
  logic take_s;
  rgbhsv_pkg::cell_data_t data_next;

  // One restoring step for each divider, then move both divisors down a bit.
  always_comb begin
    dh = rgbhsv_pkg::REMH_W'(in_data.dsh_h);
    ds = rgbhsv_pkg::REMH_W'(in_data.dsh_s);
    rs_wide = rgbhsv_pkg::REMH_W'(in_data.rem_s);
    take_h = (in_data.rem_h >= dh);
    take_s = (rs_wide >= ds);
    data_next = in_data;
    data_next.rem_h = take_h ? (in_data.rem_h - dh) : in_data.rem_h;
    data_next.q_h = {in_data.q_h[rgbhsv_pkg::QH_W-2:0], take_h};
    data_next.rem_s = take_s ? rgbhsv_pkg::REMS_W'(rs_wide - ds) : in_data.rem_s;
    data_next.q_s = {in_data.q_s[rgbhsv_pkg::QS_W-2:0], take_s};
    data_next.dsh_h = in_data.dsh_h >> 1;
    data_next.dsh_s = in_data.dsh_s >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= data_next;
    end
  end

endmodule

// File: design/rgb_to_hsv_unit.sv
// Hexcone RGB-to-HSV converter. It takes one pixel per clock while the output is
// not stalled, and returns hue in 1/64 degree (0 to 23039), saturation (255 is
// fully saturated) and brightness (the largest channel). A pixel goes through an
// input stage that finds the sector and forms the dividends, a row of twelve
// divider cells that each settle one quotient bit of the hue and saturation
// divisions, and an output register. A stalled output holds only the stages
// behind it that are full; empty stages still fill.
module rgb_to_hsv_unit (
  input  logic clk,
  input  logic rst,
  rgbhsv_pix_if.sink pixel,
  rgbhsv_hsv_if.source result
);

  localparam int NC = rgbhsv_pkg::NUM_CELLS;

  logic stage_valid [0:NC];
  rgbhsv_pkg::cell_data_t stage_data [0:NC];
  logic load [0:NC];
  logic load_out;

  logic out_valid;
  logic [rgbhsv_pkg::HUE_W-1:0] out_hue;
  logic [7:0] out_sat;
  logic [7:0] out_bright;
  logic [rgbhsv_pkg::HUE_W-1:0] hue_next;
  logic [rgbhsv_pkg::HUE_W-1:0] q_ext;
  rgbhsv_pkg::cell_data_t last;

  // Load chain: a stage takes new data when it is empty or its successor moves.
  assign load_out = !out_valid || result.ready;
  assign load[NC] = !stage_valid[NC] || load_out;

  genvar i;
  generate
    for (i = 0; i < NC; i++) begin : g_load
      assign load[i] = !stage_valid[i] || load[i+1];
    end
  endgenerate

  assign pixel.ready = load[0];

  rgbhsv_front u_front (
    .clk(clk),
    .rst(rst),
    .load(load[0]),
    .in_valid(pixel.valid),
    .red(pixel.red),
    .green(pixel.green),
    .blue(pixel.blue),
    .out_valid(stage_valid[0]),
    .out_data(stage_data[0])
  );

  // Divider row: one quotient bit per cell.
  generate
    for (i = 0; i < NC; i++) begin : g_cell
      rgbhsv_cell u_cell (
        .clk(clk),
        .rst(rst),
        .load(load[i+1]),
        .in_valid(stage_valid[i]),
        .in_data(stage_data[i]),
        .out_valid(stage_valid[i+1]),
        .out_data(stage_data[i+1])
      );
    end
  endgenerate

  // Apply the sector offset; grey pixels give zero hue and saturation.
  always_comb begin
    last = stage_data[NC];
    q_ext = rgbhsv_pkg::HUE_W'(last.q_h);
    if (last.zero) begin
      hue_next = '0;
    end else if (last.neg) begin
      hue_next = last.off - q_ext;
    end else begin
      hue_next = last.off + q_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= stage_valid[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hue <= hue_next;
      out_sat <= last.zero ? 8'd0 : last.q_s;
      out_bright <= last.bright;
    end
  end

  assign result.valid = out_valid;
  assign result.hue = out_hue;
  assign result.saturation = out_sat;
  assign result.brightness = out_bright;

  // A delivered hue stays below a full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_hue < rgbhsv_pkg::HUE_FULL))
    else $error("hue out of range");

  // A black pixel has no saturation and no hue.
  a_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bright == 8'd0) |-> (out_sat == 8'd0 && out_hue == '0))
    else $error("black pixel with nonzero hue or saturation");

  // An accepted pixel lands in the input stage.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> stage_valid[0])
    else $error("accepted pixel lost at input stage");

  // The hue quotient never exceeds one sector.
  a_quot: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[NC] && !last.zero) |-> (q_ext <= rgbhsv_pkg::HUE_SECTOR))
    else $error("hue quotient exceeds one sector");

endmodule

// File: test/rgb_to_hsv_unit_checker.sv
// Watches both channels of the converter, works out the HSV triple of every
// accepted pixel request and compares it with the result requests in order.
module rgb_to_hsv_unit_checker (
  input  logic clk,
  input  logic rst,
  rgbhsv_pix_if pixel,
  rgbhsv_hsv_if result,
  output int mismatches,
  output int pending,
  output int checked
);

  typedef struct packed {
    logic [rgbhsv_pkg::HUE_W-1:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  // Triples still owed by the converter, oldest first.
  hsv_t hsv_due[$];

  // Hexcone conversion in fixed point: hue in 1/64 degree, truncating division.
  function automatic hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned hi;
    int unsigned lo;
    int unsigned span;
    int unsigned mag;
    int unsigned quot;
    logic [rgbhsv_pkg::HUE_W-1:0] base;
    logic rising;
    hsv_t res;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    span = hi - lo;
    res.brightness = hi[7:0];
    res.saturation = (hi == 0) ? 8'd0 : 8'((255 * span) / hi);
    if (span == 0) begin
      res.hue = '0;
    end else begin
      // The sector goes to red on a tie with red, then to green.
      if (hi == r) begin
        rising = (g >= b);
        mag = rising ? g - b : b - g;
        base = rising ? '0 : rgbhsv_pkg::HUE_FULL;
      end else if (hi == g) begin
        rising = (b >= r);
        mag = rising ? b - r : r - b;
        base = rgbhsv_pkg::HUE_GREEN_BASE;
      end else begin
        rising = (r >= g);
        mag = rising ? r - g : g - r;
        base = rgbhsv_pkg::HUE_BLUE_BASE;
      end
      quot = (32'(rgbhsv_pkg::HUE_SECTOR) * mag) / span;
      res.hue = rising ? base + rgbhsv_pkg::HUE_W'(quot) : base - rgbhsv_pkg::HUE_W'(quot);
    end
    return res;
  endfunction

  // Prints one line per problem and counts it.
  task automatic report_error(string msg);
    $display("error at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Compare the result request first, then queue the pixel request of this edge.
  always @(posedge clk) begin
    hsv_t want;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (hsv_due.size() == 0) begin
          report_error($sformatf("unexpected result hue %0d sat %0d bright %0d",
                                 result.hue, result.saturation, result.brightness));
        end else begin
          want = hsv_due.pop_front();
          if (result.hue !== want.hue)
            report_error($sformatf("result %0d: hue %0d, expected %0d",
                                   checked, result.hue, want.hue));
          if (result.saturation !== want.saturation)
            report_error($sformatf("result %0d: saturation %0d, expected %0d",
                                   checked, result.saturation, want.saturation));
          if (result.brightness !== want.brightness)
            report_error($sformatf("result %0d: brightness %0d, expected %0d",
                                   checked, result.brightness, want.brightness));
          checked++;
        end
      end
      if (pixel.valid && pixel.ready)
        hsv_due.push_back(convert_pixel(pixel.red, pixel.green, pixel.blue));
    end
    pending <= hsv_due.size();
  end

endmodule

// File: test/rgb_to_hsv_unit_tb.sv
// Drives pixel requests into the converter with random gaps and stalls, and
// leaves prediction and comparison to the checker beside it.
module rgb_to_hsv_unit_tb;

  localparam int RANDOM_PIXELS = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_CORNERS = 25;
  localparam int SETTLE_CYCLES = 20;

  logic clk;
  logic rst;
  logic sink_ready = 1'b0;
  bit src_quiet;
  bit sink_quiet;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;
  int mismatches;
  int pending;
  int checked;

  // Corners: black, greys, pure and mixed primaries, sector ties, the red
  // wrap, one-step differences and alternating bit patterns.
  logic [23:0] corners [NUM_CORNERS] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001,
    24'hFF0100, 24'h010000, 24'h010100, 24'h000101, 24'h010001,
    24'hFFFEFE, 24'hFEFF00, 24'h00FEFF, 24'h64FFC8, 24'hC8FF64,
    24'h6432FF, 24'h3264FF, 24'hFF8000, 24'hAA55AA, 24'h55AA55
  };

  rgbhsv_pix_if pixel_ch ();
  rgbhsv_hsv_if result_ch ();

  assign result_ch.ready = sink_ready;

  rgb_to_hsv_unit u_dut (
    .clk(clk),
    .rst(rst),
    .pixel(pixel_ch),
    .result(result_ch)
  );

  rgb_to_hsv_unit_checker u_checker (
    .clk(clk),
    .rst(rst),
    .pixel(pixel_ch),
    .result(result_ch),
    .mismatches(mismatches),
    .pending(pending),
    .checked(checked)
  );

  // Clock with a period of 8.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Idle lengths: mostly none or short, now and then long.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls unless a quiet stretch is on.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      sink_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      sink_ready <= 1'b1;
      if (!sink_quiet && !rst) hold_left <= idle_len();
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // Offers one pixel request after an optional gap and waits until it is taken.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    gap = src_quiet ? 0 : idle_len();
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.red <= r;
    pixel_ch.green <= g;
    pixel_ch.blue <= b;
    do @(posedge clk); while (!pixel_ch.ready);
    sent++;
  endtask

  // Holds off new requests until every outstanding result is back.
  task automatic drain_results();
    pixel_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Picks a channel value, leaning toward the ends of the range.
  function automatic logic [7:0] edgy_value();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int pick;
    pixel_ch.valid <= 1'b0;
    pixel_ch.red <= 8'd0;
    pixel_ch.green <= 8'd0;
    pixel_ch.blue <= 8'd0;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed corners.
    foreach (corners[i]) send_pixel(corners[i][23:16], corners[i][15:8], corners[i][7:0]);
    drain_results();

    // Random pixels, with quiet stretches on either side in turn.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      src_quiet = ((i / 100) % 4) inside {1, 3};
      sink_quiet = ((i / 100) % 4) inside {2, 3};
      if (i == RANDOM_PIXELS / 2) drain_results();
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick >= 60 && pick < 70) begin
        // Grey pixel.
        g = r;
        b = r;
      end else if (pick >= 70 && pick < 82) begin
        // Two channels tied, often for the maximum.
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end else if (pick >= 82 && pick < 92) begin
        r = edgy_value();
        g = edgy_value();
        b = edgy_value();
      end else if (pick >= 92) begin
        case ($urandom_range(0, 2))
          0: r = 8'd255;
          1: g = 8'd255;
          default: b = 8'd255;
        endcase
      end
      send_pixel(r, g, b);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pixels: %0d corner cases, then random ones with gaps and stalls",
             sent, NUM_CORNERS);
    $display("%0d results compared field by field, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: rgb_to_hsv_unit.f
design/rgbhsv_pkg.sv
design/rgbhsv_if.sv
design/rgbhsv_front.sv
design/rgbhsv_cell.sv
design/rgb_to_hsv_unit.sv
test/rgb_to_hsv_unit_checker.sv
test/rgb_to_hsv_unit_tb.sv
